### hw/rtl/tis_pkg.sv
// Package for the trapezoid sqrt integrator: widths and status codes.
// No dependencies.
`default_nettype none
package tis_pkg;
	localparam int LimW = 24;
	localparam int CntW = 13;
	localparam int XW   = 32;   // Q8.24 sample point
	localparam int RadW = 40;   // radicand X << 8
	localparam int RootW = 20;
	localparam int SumW = 34;
	localparam int ResW = 32;

	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_BAD = 1'b1;
endpackage
`default_nettype wire

### hw/rtl/trapezoid_integrate_sqrt.sv
// Trapezoid-rule integral of sqrt(x) over [a,b]; top level and sequencer.
// Depends on tis_pkg, tis_div, tis_sqrt.
//
// Input stream s_axis: one transfer carries both limits (Q8.16) and the
// point count. Output stream m_axis: integral (signed Q16.16) and status.
// s_axis_tready is high only while the block is idle; one item is worked
// at a time. It runs a step division, then one square root per sample
// point (n points, ends included) on the one shared square-root unit,
// then a multiply in the states MUL1 and MUL2. A count below two answers
// in the cycle after its transfer, with status 1.
// The result stays in an output register until taken; while the receiver
// stalls the block holds and takes no new item. The input is ready again
// the cycle after the output transfer. Reset empties everything.
`default_nettype none
module trapezoid_integrate_sqrt
	import tis_pkg::*;
#(
	parameter int MAX_POINTS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [23:0] lower_limit, [47:24] upper_limit, [60:48] point_count
	input  wire logic [63:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [31:0] integral
	output logic [31:0]      m_axis_tdata,
	// [0] status
	output logic             m_axis_tuser
);
	typedef enum logic [2:0] {IDLE, DIV, ROOT, MUL1, MUL2, OUT} state_t;
	state_t state_q;

	logic [LimW-1:0] a_in, b_in, lo_q, hi_q;
	logic [CntW-1:0] n_in;
	logic [CntW-1:0] n_q, i_q;
	logic [XW-1:0]   h_q, x_q;
	logic [SumW-1:0] sum_q;
	logic            flip_q;
	logic [48:0]     part_q;
	logic [16:0]     mul_b;
	logic [48:0]     mul_p;
	logic [65:0]     full;

	logic div_start, div_done, sq_start, sq_done;
	logic [XW-1:0] div_q;
	logic [RootW-1:0] root;
	logic [LimW-1:0] diff;
	logic [CntW-1:0] nm1_in;
	logic [CntW-1:0] n_sat;

	assign a_in = s_axis_tdata[23:0];
	assign b_in = s_axis_tdata[47:24];
	assign n_in = s_axis_tdata[60:48];
	assign s_axis_tready = (state_q == IDLE);
	assign diff = (a_in > b_in) ? a_in - b_in : b_in - a_in;

	assign n_sat  = (int'(n_in) > MAX_POINTS) ? CntW'(MAX_POINTS) : n_in;
	assign nm1_in = n_sat - CntW'(1);
	assign div_start = s_axis_tvalid && s_axis_tready && (n_in >= 13'd2);

	tis_div u_div (.clk, .arst_n, .start(div_start),
		.dividend({diff, 8'd0}), .divisor(nm1_in), .done(div_done), .quotient(div_q));

	tis_sqrt u_sqrt (.clk, .arst_n, .start(sq_start),
		.radicand({x_q, 8'd0}), .done(sq_done), .root(root));

	// one 32x17 multiplier, low half of the sum first, then the high half
	assign mul_b = (state_q == MUL1) ? sum_q[16:0] : sum_q[SumW-1:17];
	assign mul_p = 49'(h_q) * 49'(mul_b);
	always_comb full = {mul_p, 17'd0} + 66'(part_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= STAT_OK;
			sq_start      <= 1'b0;
			flip_q        <= 1'b0;
			lo_q          <= '0;
			hi_q          <= '0;
			n_q           <= '0;
			i_q           <= '0;
			h_q           <= '0;
			x_q           <= '0;
			sum_q         <= '0;
			part_q        <= '0;
		end else begin
			sq_start <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (s_axis_tvalid) begin
						flip_q <= a_in > b_in;
						lo_q   <= (a_in > b_in) ? b_in : a_in;
						// upper limit kept so the end point is taken exactly at hi
						hi_q   <= (a_in > b_in) ? a_in : b_in;
						n_q    <= n_sat;
						sum_q  <= '0;
						i_q    <= '0;
						if (n_in < 13'd2) begin
							m_axis_tdata  <= '0;
							m_axis_tuser  <= STAT_BAD;
							m_axis_tvalid <= 1'b1;
							state_q       <= OUT;
						end else begin
							state_q <= DIV;
						end
					end
				end
				DIV: begin
					if (div_done) begin
						h_q      <= div_q;
						x_q      <= {lo_q, 8'd0};
						sq_start <= 1'b1;
						state_q  <= ROOT;
					end
				end
				ROOT: begin
					if (sq_done) begin
						if (i_q == '0 || i_q == n_q - CntW'(1))
							sum_q <= sum_q + SumW'(root);
						else
							sum_q <= sum_q + SumW'({root, 1'b0});
						i_q <= i_q + CntW'(1);
						if (i_q == n_q - CntW'(1)) begin
							state_q <= MUL1;
						end else begin
							sq_start <= 1'b1;
							if (i_q + CntW'(1) == n_q - CntW'(1))
								x_q <= {hi_q, 8'd0};
							else
								x_q <= x_q + h_q;
						end
					end
				end
				MUL1: begin
					part_q  <= mul_p;
					state_q <= MUL2;
				end
				MUL2: begin
					m_axis_tdata  <= flip_q ? 32'(-full[56:25]) : full[56:25];
					m_axis_tuser  <= STAT_OK;
					m_axis_tvalid <= 1'b1;
					state_q       <= OUT;
				end
				OUT: begin
					if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						state_q       <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### hw/rtl/tis_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tis_pkg.
`default_nettype none
module tis_div
	import tis_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [XW-1:0]   dividend,
	input  wire logic [CntW-1:0] divisor,
	output logic                 done,
	output logic [XW-1:0]        quotient
);
	logic [XW-1:0]   num_q;
	logic [CntW:0]   rem_q;
	logic [CntW-1:0] den_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic [CntW+1:0] trial;

	assign trial = {rem_q, num_q[XW-1]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				num_q  <= dividend;
				den_q  <= divisor;
				rem_q  <= '0;
				cnt_q  <= 6'(XW);
			end else if (busy_q) begin
				if (!trial[CntW+1]) begin
					rem_q <= trial[CntW:0];
					num_q <= {num_q[XW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[CntW-1:0], num_q[XW-1]};
					num_q <= {num_q[XW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	assign quotient = num_q;
endmodule
`default_nettype wire

### hw/rtl/tis_sqrt.sv
// Bit-pair integer square root, one result bit per cycle, truncated.
// Depends on tis_pkg.
`default_nettype none
module tis_sqrt
	import tis_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [RadW-1:0]  radicand,
	output logic                  done,
	output logic [RootW-1:0]      root
);
	logic [RadW-1:0]  v_q;
	logic [RadW-1:0]  res_q;
	logic [RadW-1:0]  bit_q;
	logic             busy_q;
	logic [RadW-1:0]  trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			v_q    <= '0;
			res_q  <= '0;
			bit_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				v_q    <= radicand;
				res_q  <= '0;
				bit_q  <= {2'b01, {(RadW-2){1'b0}}};
			end else if (busy_q) begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	assign root = res_q[RootW-1:0];
endmodule
`default_nettype wire

### tb/sv/trapezoid_integrate_sqrt_checker.sv
// Checker for the trapezoid sqrt integrator: watches both streams, predicts
// each result in fixed point and compares. Depends on tis_pkg.
module trapezoid_integrate_sqrt_checker
	import tis_pkg::*;
#(
	parameter int MAX_POINTS = 4096
) (
	input  wire logic        clk,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [31:0] m_axis_tdata,
	input  wire logic        m_axis_tuser,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] integral;
		logic        status;
	} answer_t;

	answer_t answers[$];

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res >>= 1;
			end
			bit_w >>= 2;
		end
		return res;
	endfunction

	function automatic answer_t integrate_sqrt(logic [63:0] word);
		answer_t r;
		logic [63:0] a, b, n, lo, hi, h, interior, total, mag;
		logic flip;
		a = 64'(word[23:0]);
		b = 64'(word[47:24]);
		n = 64'(word[60:48]);
		if (n < 2) begin
			r.integral = 32'd0;
			r.status = STAT_BAD;
			return r;
		end
		if (n > 64'(MAX_POINTS))
			n = 64'(MAX_POINTS);
		flip = a > b;
		lo = flip ? b : a;
		hi = flip ? a : b;
		h = ((hi - lo) << 8) / (n - 1);
		interior = 0;
		for (logic [63:0] i = 1; i + 1 < n; i++)
			interior += isqrt(((lo << 8) + i * h) << 8);
		total = isqrt(lo << 16) + isqrt(hi << 16) + 2 * interior;
		mag = (h * total) >> 25;
		if (flip)
			mag = 64'd0 - mag;
		r.integral = mag[31:0];
		r.status = STAT_OK;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		answer_t w;
		if (s_axis_tvalid && s_axis_tready)
			answers.push_back(integrate_sqrt(s_axis_tdata));
		if (m_axis_tvalid && m_axis_tready) begin
			if (answers.size() == 0) begin
				report("unexpected transfer", m_axis_tdata, 32'd0);
			end else begin
				w = answers.pop_front();
				if (m_axis_tdata !== w.integral)
					report("integral", m_axis_tdata, w.integral);
				if (m_axis_tuser !== w.status)
					report("status", 32'(m_axis_tuser), 32'(w.status));
			end
		end
		pending = answers.size();
	end
endmodule

### tb/sv/trapezoid_integrate_sqrt_tb.sv
// Top of the trapezoid sqrt integrator testbench: clock, reset, stimulus,
// receiver stalls and verdict. Depends on the block and the checker module.
module trapezoid_integrate_sqrt_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 400000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	int          errors, pending;
	int          quiet = 0;
	bit          hold_off = 0;

	always #5 clk = ~clk;

	trapezoid_integrate_sqrt dut (.*);
	trapezoid_integrate_sqrt_checker chk (.*);

	function automatic int gap();
		return ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(2);
	endfunction

	// limits mostly random; count mostly small so the run stays short
	function automatic logic [63:0] rand_item();
		logic [23:0] a, b;
		logic [12:0] n;
		a = 24'($urandom);
		b = 24'($urandom);
		n = 13'($urandom_range(2, 40));
		case ($urandom_range(9))
			0: n = 13'($urandom_range(1));
			1: n = 13'h1FFF ^ 13'($urandom_range(255));
			2: b = a;
			default: ;
		endcase
		if ($urandom_range(9) < 8 && n > 40)
			n = 13'($urandom_range(2, 40));
		return {3'b0, n, b, a};
	endfunction

	task automatic send(logic [23:0] a, logic [23:0] b, logic [12:0] n);
		int g;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b0, n, b, a};
		do @(posedge clk); while (!s_axis_tready);
		g = gap();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_axis_tready <= 0;
				repeat (3000) @(posedge clk);
				hold_off = 0;
			end
			m_axis_tready <= ($urandom_range(3) != 0) || ($urandom_range(7) == 0);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= StallLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [63:0] w;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);
		send(24'h0, 24'hFFFFFF, 13'd2);
		send(24'hFFFFFF, 24'h0, 13'd2);
		send(24'h010000, 24'h040000, 13'd0);
		send(24'h010000, 24'h040000, 13'd1);
		send(24'h010000, 24'h040000, 13'd3);
		send(24'h040000, 24'h010000, 13'd5);
		send(24'h123456, 24'h123456, 13'd17);
		send(24'h0, 24'h0, 13'd2);
		send(24'h0, 24'hFFFFFF, 13'd4096);
		send(24'hFFFFFF, 24'h0, 13'h1FFF);
		send(24'hAAAAAA, 24'h555555, 13'h0AAA);
		send(24'h555555, 24'hAAAAAA, 13'd4097);
		send(24'h000001, 24'h000002, 13'd7);
		hold_off = 1;
		for (int i = 0; i < 6; i++)
			send(24'($urandom), 24'($urandom), 13'($urandom_range(2, 20)));
		for (int i = 0; i < 81; i++) begin
			w = rand_item();
			send(w[23:0], w[47:24], w[60:48]);
		end
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
